// ===== src/sha256_message_hasher_macros.svh =====
// Assertion macros for the SHA-256 message hasher.
// Used by the RTL files that carry concurrent assertions.
`ifndef SHA256_MESSAGE_HASHER_MACROS_SVH
`define SHA256_MESSAGE_HASHER_MACROS_SVH
// assert that a implies b on the next cycle
`define SHA_ASSERT_NEXT(lbl, clk, rstn, a, b) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (a) |=> (b)) else $error("assertion failed");
// assert a condition on every cycle
`define SHA_ASSERT_ALWAYS(lbl, clk, rstn, a) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (a)) else $error("assertion failed");
`endif

// ===== src/sha_pkg.sv =====
// Constants, types and round functions for the SHA-256 message hasher.
// No dependencies.
`default_nettype none
package sha_pkg;
  localparam logic [31:0] InitH [8] = '{
    32'h6A09E667, 32'hBB67AE85, 32'h3C6EF372, 32'hA54FF53A,
    32'h510E527F, 32'h9B05688C, 32'h1F83D9AB, 32'h5BE0CD19};
  localparam logic [31:0] RoundK [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
    32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
    32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
    32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
    32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
    32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};
  localparam logic [7:0] PadByte = 8'h80;
  localparam logic [5:0] LenPos = 6'd56;

  typedef struct packed {
    logic [7:0] data_byte;
    logic has_byte;
    logic last;
  } in_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0] word_index;
    logic last_word;
  } out_t;

  typedef struct packed {
    logic start;
    logic busy;
  } core_ctl_t;

  function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
    rotr = (x >> n) | (x << (32 - n));
  endfunction
endpackage
`default_nettype wire

// ===== src/sha_if.sv =====
// Valid/ready channel carrying one request.
// Depends on sha_pkg for nothing; payload type is a parameter.
`default_nettype none
interface sha_if #(parameter type T = logic) ();
  logic valid;
  logic ready;
  T payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface
`default_nettype wire

// ===== src/sha_core.sv =====
// 64-round SHA-256 compression, one round per cycle, with rolling schedule.
// Depends on sha_pkg.
`default_nettype none
module sha_core (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire sha_pkg::core_ctl_t ctl_i,
  input  wire logic [31:0] wblk_i [16],
  input  wire logic [31:0] h_i [8],
  output logic [31:0] h_o [8],
  output logic done_o
);
  import sha_pkg::*;
  logic [31:0] w_q [16];
  logic [31:0] v_q [8];
  logic [5:0] rnd_q;
  logic run_q;
  logic [31:0] s0, s1, wn, t1, t2, e, a;

  always_comb begin
    s0 = rotr(w_q[1], 7) ^ rotr(w_q[1], 18) ^ (w_q[1] >> 3);
    s1 = rotr(w_q[14], 17) ^ rotr(w_q[14], 19) ^ (w_q[14] >> 10);
    wn = s1 + w_q[9] + s0 + w_q[0];
    e = v_q[4];
    a = v_q[0];
    t1 = v_q[7] + (rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25)) + (v_q[6] ^ (e & (v_q[5] ^ v_q[6])))
         + RoundK[rnd_q] + w_q[0];
    t2 = (rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22)) + ((a & v_q[1]) | (v_q[2] & (a | v_q[1])));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q <= 1'b0;
      rnd_q <= '0;
      done_o <= 1'b0;
    end else begin
      done_o <= 1'b0;
      if (ctl_i.start) begin
        run_q <= 1'b1;
        rnd_q <= '0;
      end else if (run_q) begin
        rnd_q <= rnd_q + 6'd1;
        if (rnd_q == 6'd63) begin
          run_q <= 1'b0;
          done_o <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.start) begin
      w_q <= wblk_i;
      v_q <= h_i;
    end else if (run_q) begin
      for (int i = 0; i < 15; i++) w_q[i] <= w_q[i+1];
      w_q[15] <= wn;
      v_q[7] <= v_q[6]; v_q[6] <= v_q[5]; v_q[5] <= v_q[4];
      v_q[4] <= v_q[3] + t1;
      v_q[3] <= v_q[2]; v_q[2] <= v_q[1]; v_q[1] <= v_q[0];
      v_q[0] <= t1 + t2;
    end
  end

  always_comb for (int i = 0; i < 8; i++) h_o[i] = h_i[i] + v_q[i];

  `include "sha256_message_hasher_macros.svh"
  `SHA_ASSERT_NEXT(a_done_pulse, clk_i, rst_ni, done_o, !done_o)
  `SHA_ASSERT_NEXT(a_last_round, clk_i, rst_ni, run_q && rnd_q == 6'd63 && !ctl_i.start, done_o)
  `SHA_ASSERT_ALWAYS(a_no_restart, clk_i, rst_ni, !(ctl_i.start && run_q))
endmodule
`default_nettype wire

// ===== src/sha256_message_hasher.sv =====
// Top level of the SHA-256 message hasher: byte buffer, padding sequencer,
// digest output. Depends on sha_pkg, sha_if and sha_core.
//   channel  dir  payload
//   in_if    in   data_byte, has_byte, last
//   out_if   out  digest_word, word_index, last_word
// A byte that fills no block is written into the buffer. A full block adds a pass of
// compression (64 rounds in sha_core plus start and fold). A last request adds
// one or two padded blocks, then eight words that wait on out_if.ready.
// Not ready while compressing or emitting. Reset restores the initial hash.
`default_nettype none
module sha256_message_hasher (
  input wire logic clk_i,
  input wire logic rst_ni,
  sha_if.sink in_if,
  sha_if.source out_if
);
  import sha_pkg::*;
  typedef enum logic [4:0] {
    SIdle = 5'b00001, SComp = 5'b00010, SPad = 5'b00100, SPadComp = 5'b01000,
    SOut = 5'b10000
  } state_e;
  state_e st_q;
  logic [31:0] wbuf_q [16];
  logic [5:0] fill_q;
  logic [63:0] bits_q;
  logic [31:0] h_q [8];
  logic [31:0] h_new [8];
  logic fin_q, kick_q, done;
  logic [2:0] oidx_q;
  core_ctl_t ctl;
  in_t req;
  logic pad_two;
  logic second_q;
  logic len_here;
  logic fin_pad_q;

  assign req = in_if.payload;
  assign in_if.ready = (st_q == SIdle);
  assign ctl.start = kick_q;
  assign ctl.busy = st_q inside {SComp, SPadComp};

  sha_core u_core (.clk_i, .rst_ni, .ctl_i(ctl), .wblk_i(wbuf_q), .h_i(h_q),
                   .h_o(h_new), .done_o(done));

  assign out_if.valid = (st_q == SOut);
  assign out_if.payload = '{digest_word: h_q[oidx_q], word_index: oidx_q,
                            last_word: oidx_q == 3'd7};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= SIdle; fill_q <= '0; bits_q <= '0; fin_q <= 1'b0; kick_q <= 1'b0;
      oidx_q <= '0; h_q <= InitH;
    end else begin
      kick_q <= 1'b0;
      case (st_q)
        SIdle: begin
          if (in_if.valid) begin
            fin_q <= req.last;
            if (req.has_byte) begin
              fill_q <= fill_q + 6'd1;
              bits_q <= bits_q + 64'd8;
            end
            if (req.has_byte && fill_q == 6'd63) begin
              st_q <= SComp; kick_q <= 1'b1;
            end else if (req.last) begin
              st_q <= SPad;
            end
          end
        end
        SComp: if (done) begin
          h_q <= h_new;
          st_q <= fin_q ? SPad : SIdle;
        end
        SPad: begin
          // pad byte at fill, zeros after; length if it fits, else zeros and length in a second block
          fill_q <= '0; kick_q <= 1'b1; st_q <= SPadComp;
        end
        SPadComp: if (done) begin
          h_q <= h_new;
          st_q <= fin_pad_q ? SOut : SPad;
        end
        SOut: if (out_if.ready) begin
          oidx_q <= oidx_q + 3'd1;
          if (oidx_q == 3'd7) begin
            st_q <= SIdle; h_q <= InitH; bits_q <= '0; fin_q <= 1'b0;
          end
        end
        default: st_q <= SIdle;
      endcase
    end
  end

  // second_q marks the length-only block of a two-block pad
  assign pad_two = fill_q > 6'd55;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) second_q <= 1'b0;
    else if (st_q == SIdle) second_q <= 1'b0;
    else if (st_q == SPadComp && done && !fin_pad_q) second_q <= 1'b1;
  end

  always_ff @(posedge clk_i) begin
    if (st_q == SIdle && in_if.valid && req.has_byte)
      wbuf_q[fill_q[5:2]][{~fill_q[1:0], 3'b000} +: 8] <= req.data_byte;
    if (st_q == SPad) begin
      for (int i = 0; i < 64; i++) begin
        if (second_q)
          wbuf_q[4'(i >> 2)][8*(3-(i & 3)) +: 8] <= (i >= 56) ? bits_q[8*(63-i) +: 8] : 8'h00;
        else if (i == int'(fill_q)) wbuf_q[4'(i >> 2)][8*(3-(i & 3)) +: 8] <= PadByte;
        else if (i > int'(fill_q)) begin
          if (!pad_two && i >= int'(LenPos))
            wbuf_q[4'(i >> 2)][8*(3-(i & 3)) +: 8] <= bits_q[8*(63-i) +: 8];
          else wbuf_q[4'(i >> 2)][8*(3-(i & 3)) +: 8] <= 8'h00;
        end
      end
    end
  end

  // fin_pad_q marks the block carrying the length
  assign len_here = second_q || !pad_two;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) fin_pad_q <= 1'b0;
    else if (st_q == SPad) fin_pad_q <= len_here;
  end

  `include "sha256_message_hasher_macros.svh"
  `SHA_ASSERT_NEXT(a_out_stall, clk_i, rst_ni, out_if.valid && !out_if.ready, out_if.valid)
  `SHA_ASSERT_ALWAYS(a_busy_not_ready, clk_i, rst_ni, !(ctl.busy && in_if.ready))
  `SHA_ASSERT_NEXT(a_pad_kicks, clk_i, rst_ni, st_q == SPad, kick_q)
endmodule
`default_nettype wire

// ===== bench/sha256_message_hasher_test.sv =====
// Self-checking bench for sha256_message_hasher: drives byte requests, predicts
// the SHA-256 digest words and compares them with the block's output stream.
// Depends on sha_pkg, sha_if and the RTL of sha256_message_hasher.
`timescale 1ns / 1ps
module sha256_message_hasher_test;
  import sha_pkg::*;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  sha_if #(.T(in_t)) in_if ();
  sha_if #(.T(out_t)) out_if ();

  sha256_message_hasher dut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .in_if(in_if),
    .out_if(out_if)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // hash state mirror
  logic [31:0] hash_h [8];
  logic [7:0] msg_block [64];
  int unsigned msg_fill;
  logic [63:0] msg_bits;

  in_t req_queue [$];
  out_t digest_queue [$];
  int unsigned fail_count = 0;
  bit hold_off = 1'b0;
  bit sender_done = 1'b0;
  bit pause_sender = 1'b0;

  function automatic logic [31:0] ror32(logic [31:0] x, int unsigned n);
    return (x >> n) | (x << (32 - n));
  endfunction

  function automatic void hash_reset();
    for (int i = 0; i < 8; i++) hash_h[i] = InitH[i];
    for (int i = 0; i < 64; i++) msg_block[i] = 8'h00;
    msg_fill = 0;
    msg_bits = '0;
  endfunction

  function automatic void compress();
    logic [31:0] w [64];
    logic [31:0] v [8];
    logic [31:0] s0, s1, t1, t2;
    for (int r = 0; r < 16; r++)
      w[r] = {msg_block[4*r], msg_block[4*r+1], msg_block[4*r+2], msg_block[4*r+3]};
    for (int r = 16; r < 64; r++) begin
      s0 = ror32(w[r-15], 7) ^ ror32(w[r-15], 18) ^ (w[r-15] >> 3);
      s1 = ror32(w[r-2], 17) ^ ror32(w[r-2], 19) ^ (w[r-2] >> 10);
      w[r] = s1 + w[r-7] + s0 + w[r-16];
    end
    for (int i = 0; i < 8; i++) v[i] = hash_h[i];
    for (int r = 0; r < 64; r++) begin
      t1 = v[7] + (ror32(v[4], 6) ^ ror32(v[4], 11) ^ ror32(v[4], 25))
         + (v[6] ^ (v[4] & (v[5] ^ v[6]))) + RoundK[r] + w[r];
      t2 = (ror32(v[0], 2) ^ ror32(v[0], 13) ^ ror32(v[0], 22))
         + ((v[0] & v[1]) | (v[2] & (v[0] | v[1])));
      v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
      v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
    end
    for (int i = 0; i < 8; i++) hash_h[i] += v[i];
  endfunction

  function automatic void predict_digest(in_t req);
    out_t word;
    if (req.has_byte) begin
      msg_block[msg_fill] = req.data_byte;
      msg_fill++;
      msg_bits += 64'd8;
      if (msg_fill == 64) begin
        compress();
        msg_fill = 0;
      end
    end
    if (!req.last) return;
    msg_block[msg_fill] = PadByte;
    msg_fill++;
    if (msg_fill > LenPos) begin
      while (msg_fill < 64) begin
        msg_block[msg_fill] = 8'h00;
        msg_fill++;
      end
      compress();
      msg_fill = 0;
    end
    while (msg_fill < LenPos) begin
      msg_block[msg_fill] = 8'h00;
      msg_fill++;
    end
    for (int k = 0; k < 8; k++) msg_block[56+k] = msg_bits[63-8*k -: 8];
    compress();
    for (int k = 0; k < 8; k++) begin
      word.digest_word = hash_h[k];
      word.word_index = 3'(k);
      word.last_word = (k == 7);
      digest_queue.push_back(word);
    end
    hash_reset();
  endfunction

  function automatic void add_message(int unsigned len, bit with_idle);
    in_t req;
    for (int i = 0; i < len; i++) begin
      if (with_idle && $urandom_range(0, 7) == 0) begin
        req.data_byte = 8'($urandom);
        req.has_byte = 1'b0;
        req.last = 1'b0;
        req_queue.push_back(req);
      end
      req.data_byte = 8'($urandom);
      req.has_byte = 1'b1;
      req.last = 1'b0;
      req_queue.push_back(req);
    end
    req.data_byte = 8'($urandom);
    req.has_byte = $urandom_range(0, 1);
    req.last = 1'b1;
    req_queue.push_back(req);
  endfunction

  // driver
  int unsigned src_gap = 0;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_if.valid <= 1'b0;
      in_if.payload <= '0;
      src_gap <= 0;
    end else if (!in_if.valid || in_if.ready) begin
      if (in_if.valid) predict_digest(in_if.payload);
      if (src_gap != 0) begin
        src_gap <= src_gap - 1;
        in_if.valid <= 1'b0;
      end else if (req_queue.size() != 0 && !(pause_sender && digest_queue.size() != 0)) begin
        in_if.payload <= req_queue.pop_front();
        in_if.valid <= 1'b1;
        src_gap <= $urandom_range(0, 4);
      end else begin
        in_if.valid <= 1'b0;
        if (req_queue.size() == 0) sender_done <= 1'b1;
      end
    end
  end

  // monitor
  int unsigned sink_gap = 0;
  always @(posedge clk_i or negedge rst_ni) begin
    out_t exp_word;
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
      sink_gap <= 0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        if (digest_queue.size() == 0) begin
          $error("unexpected digest word %h", out_if.payload.digest_word);
          fail_count++;
        end else begin
          exp_word = digest_queue.pop_front();
          if (out_if.payload.digest_word !== exp_word.digest_word) begin
            $error("digest_word expected %h actual %h", exp_word.digest_word,
                   out_if.payload.digest_word);
            fail_count++;
          end
          if (out_if.payload.word_index !== exp_word.word_index) begin
            $error("word_index expected %0d actual %0d", exp_word.word_index,
                   out_if.payload.word_index);
            fail_count++;
          end
          if (out_if.payload.last_word !== exp_word.last_word) begin
            $error("last_word expected %0d actual %0d", exp_word.last_word,
                   out_if.payload.last_word);
            fail_count++;
          end
        end
        sink_gap <= $urandom_range(0, 4);
        out_if.ready <= 1'b0;
      end else if (hold_off) begin
        out_if.ready <= 1'b0;
      end else if (sink_gap != 0) begin
        sink_gap <= sink_gap - 1;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  initial begin
    in_t req;
    hash_reset();
    // empty message, both edge bytes, padding boundaries 55/56/63/64
    add_message(0, 0);
    req_queue[0].has_byte = 1'b0;
    req = '{data_byte: 8'hff, has_byte: 1'b1, last: 1'b1};
    req_queue.push_back(req);
    req = '{data_byte: 8'h00, has_byte: 1'b0, last: 1'b0};
    req_queue.push_back(req);
    req = '{data_byte: 8'h00, has_byte: 1'b1, last: 1'b1};
    req_queue.push_back(req);
    add_message(55, 0);
    add_message(56, 0);
    add_message(63, 0);
    add_message(64, 0);
    while (req_queue.size() < 275) add_message($urandom_range(0, 9), 1);
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (300) @(posedge clk_i);
    hold_off <= 1'b1;
    repeat (400) @(posedge clk_i);
    hold_off <= 1'b0;
    wait (digest_queue.size() == 0);
    pause_sender <= 1'b1;
    repeat (200) @(posedge clk_i);
    pause_sender <= 1'b0;
    wait (sender_done && !in_if.valid && digest_queue.size() == 0);
    repeat (200) @(posedge clk_i);
    if (fail_count == 0 && digest_queue.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("simulation failed");
    $finish;
  end
endmodule

// ===== filelist.f =====
+incdir+src
src/sha_pkg.sv
src/sha_if.sv
src/sha_core.sv
src/sha256_message_hasher.sv
bench/sha256_message_hasher_test.sv
